/* hw/rtl/dntr_pkg.sv */
// shared types and constants for the decimal number token recognizer
`timescale 1ns / 1ps

package dntr_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned INT_W = 32;
	localparam int unsigned CLASS_W = 2;
	localparam int unsigned OUT_W = 32;
	localparam int unsigned USER_W = 3;

	localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_INT = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_REAL = 2'd2;

	localparam logic [INT_W-1:0] POS_LIMIT = 32'h7fff_ffff;
	localparam logic [INT_W-1:0] NEG_LIMIT = 32'h8000_0000;

	localparam logic [BYTE_W-1:0] CHAR_PLUS = 8'h2b;
	localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2d;
	localparam logic [BYTE_W-1:0] CHAR_DOT = 8'h2e;
	localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;
	localparam logic [BYTE_W-1:0] CHAR_E_UP = 8'h45;
	localparam logic [BYTE_W-1:0] CHAR_E_LO = 8'h65;

	typedef struct packed {
		logic              at_first_byte;
		logic              rejected;
		logic              seen_dot;
		logic              seen_exponent;
		logic              prev_was_exponent_mark;
		logic              have_mantissa_digit;
		logic              have_exponent_digit;
		logic              is_negative;
		logic [INT_W-1:0]  magnitude;
		logic              magnitude_overflow;
	} tok_state_t;

	localparam tok_state_t TOK_RESET = '{
		at_first_byte: 1'b1,
		rejected: 1'b0,
		seen_dot: 1'b0,
		seen_exponent: 1'b0,
		prev_was_exponent_mark: 1'b0,
		have_mantissa_digit: 1'b0,
		have_exponent_digit: 1'b0,
		is_negative: 1'b0,
		magnitude: '0,
		magnitude_overflow: 1'b0
	};

	typedef struct packed {
		logic              int_out_of_range;
		logic [INT_W-1:0]  int_value;
		logic [CLASS_W-1:0] number_class;
	} tok_result_t;

endpackage

/* hw/rtl/dntr_step.sv */
// next-state and result logic for one token byte
`timescale 1ns / 1ps

module dntr_step (
	input  dntr_pkg::tok_state_t              state,
	input  logic [dntr_pkg::BYTE_W-1:0]       token_byte,
	input  logic                              last_byte,
	output dntr_pkg::tok_state_t              next_state,
	output dntr_pkg::tok_result_t             result
);

	dntr_pkg::tok_state_t upd;
	logic is_sign;
	logic is_digit;
	logic is_mark;
	logic fits;
	logic [dntr_pkg::INT_W+3:0] acc;
	logic [3:0] digit;

	assign is_sign = (token_byte == dntr_pkg::CHAR_PLUS) || (token_byte == dntr_pkg::CHAR_MINUS);
	assign is_digit = (token_byte >= dntr_pkg::CHAR_ZERO) && (token_byte <= dntr_pkg::CHAR_NINE);
	assign is_mark = (token_byte == dntr_pkg::CHAR_E_UP) || (token_byte == dntr_pkg::CHAR_E_LO);
	assign digit = token_byte[3:0];

	// magnitude * 10 + digit
	assign acc = ({4'b0, state.magnitude} << 3) + ({4'b0, state.magnitude} << 1)
		+ {{(dntr_pkg::INT_W){1'b0}}, digit};

	always_comb begin
		upd = state;
		upd.at_first_byte = 1'b0;
		upd.prev_was_exponent_mark = 1'b0;
		if (!state.rejected) begin
			if (token_byte[dntr_pkg::BYTE_W-1]) begin
				upd.rejected = 1'b1;
			end else if (state.at_first_byte && is_sign) begin
				upd.is_negative = (token_byte == dntr_pkg::CHAR_MINUS);
			end else if (is_digit) begin
				if (state.seen_exponent) begin
					upd.have_exponent_digit = 1'b1;
				end else begin
					upd.have_mantissa_digit = 1'b1;
					if (acc[dntr_pkg::INT_W+3:dntr_pkg::INT_W] != 4'd0) begin
						upd.magnitude = '1;
						upd.magnitude_overflow = 1'b1;
					end else begin
						upd.magnitude = acc[dntr_pkg::INT_W-1:0];
					end
				end
			end else if ((token_byte == dntr_pkg::CHAR_DOT) && !state.seen_dot
					&& !state.seen_exponent) begin
				upd.seen_dot = 1'b1;
			end else if (is_mark && !state.seen_exponent) begin
				upd.seen_exponent = 1'b1;
				upd.prev_was_exponent_mark = 1'b1;
			end else if (is_sign && state.seen_exponent && !state.have_exponent_digit
					&& state.prev_was_exponent_mark) begin
				upd.rejected = 1'b0;
			end else begin
				upd.rejected = 1'b1;
			end
		end
	end

	always_comb begin
		if (upd.magnitude_overflow) begin
			fits = 1'b0;
		end else if (upd.is_negative) begin
			fits = upd.magnitude <= dntr_pkg::NEG_LIMIT;
		end else begin
			fits = upd.magnitude <= dntr_pkg::POS_LIMIT;
		end
	end

	always_comb begin
		result.number_class = dntr_pkg::CLASS_NONE;
		result.int_value = '0;
		result.int_out_of_range = 1'b0;
		if (upd.rejected || !upd.have_mantissa_digit
				|| (upd.seen_exponent && !upd.have_exponent_digit)) begin
			result.number_class = dntr_pkg::CLASS_NONE;
		end else if (upd.seen_dot || upd.seen_exponent) begin
			result.number_class = dntr_pkg::CLASS_REAL;
		end else if (fits) begin
			result.number_class = dntr_pkg::CLASS_INT;
			result.int_value = upd.is_negative ? (32'd0 - upd.magnitude) : upd.magnitude;
		end else begin
			result.number_class = dntr_pkg::CLASS_REAL;
			result.int_out_of_range = 1'b1;
		end
	end

	assign next_state = last_byte ? dntr_pkg::TOK_RESET : upd;

endmodule

/* hw/rtl/decimal_number_token_recognizer.sv */
// top level of the decimal number token recognizer
//
// channel  dir  tdata              tuser                                 tlast
// s_*      in   [7:0] token_byte   -                                     last_byte
// m_*      out  [31:0] int_value   [1:0] number_class,                   -
//                                  [2] int_out_of_range
//
// one byte per cycle while no last byte waits; bytes pass an input register,
// then the token state, and a last byte's result goes to the result register
// bytes that are not last never wait on the output side
// a last byte waits in the input register while an earlier result is held
// arst_n clears the token state and both valid flags
`timescale 1ns / 1ps

module decimal_number_token_recognizer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [dntr_pkg::BYTE_W-1:0]   s_tdata,  // token_byte
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dntr_pkg::OUT_W-1:0]    m_tdata,  // int_value
	output logic [dntr_pkg::USER_W-1:0]   m_tuser   // number_class, int_out_of_range
);

	logic                          valid_s1;
	logic [dntr_pkg::BYTE_W-1:0]   byte_s1;
	logic                          last_s1;
	logic                          adv_s1;
	logic                          out_valid_q;
	dntr_pkg::tok_state_t          state_q;
	dntr_pkg::tok_state_t          next_state;
	dntr_pkg::tok_result_t         result;
	dntr_pkg::tok_result_t         result_q;

	dntr_step u_step (
		.state      (state_q),
		.token_byte (byte_s1),
		.last_byte  (last_s1),
		.next_state (next_state),
		.result     (result)
	);

	assign adv_s1 = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			state_q <= dntr_pkg::TOK_RESET;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s1) begin
				state_q <= next_state;
			end
			if (adv_s1 && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (adv_s1 && last_s1) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = result_q.int_value;
	assign m_tuser = {result_q.int_out_of_range, result_q.number_class};

endmodule

/* hw/rtl/dntr_checker.sv */
// port-level checks for the decimal number token recognizer, bound to the top level
`timescale 1ns / 1ps

module dntr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [dntr_pkg::OUT_W-1:0]    m_tdata,
	input logic [dntr_pkg::USER_W-1:0]   m_tuser
);

	// held word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	// input only stalls behind a stalled result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");

	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[1:0] == dntr_pkg::CLASS_NONE)
			|| (m_tuser[1:0] == dntr_pkg::CLASS_INT)
			|| (m_tuser[1:0] == dntr_pkg::CLASS_REAL))
		else $error("bad number class");

	a_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] != dntr_pkg::CLASS_INT) |-> m_tdata == 32'd0)
		else $error("value set on a non-integer word");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tuser[1:0] == dntr_pkg::CLASS_REAL)
		else $error("out-of-range flag without real class");

endmodule

bind decimal_number_token_recognizer dntr_checker u_dntr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* sim/testbench.sv */
// self-checking testbench for the decimal number token recognizer
`timescale 1ns / 1ps

module testbench;

	typedef logic [dntr_pkg::BYTE_W-1:0] octet_t;
	typedef octet_t octet_q_t[$];

	class literal_scoreboard;
		typedef struct {
			bit leading;
			bit dead;
			bit dot_seen;
			bit in_exp;
			bit just_marked;
			bit mant_digit;
			bit exp_digit;
			bit neg;
			logic [dntr_pkg::INT_W-1:0] mag;
			bit mag_sat;
		} scan_t;

		scan_t scan;
		dntr_pkg::tok_result_t expected_results[$];
		int unsigned errors;

		function new();
			clear_scan();
			errors = 0;
		endfunction

		function void clear_scan();
			scan = '{leading: 1'b1, dead: 1'b0, dot_seen: 1'b0, in_exp: 1'b0,
				just_marked: 1'b0, mant_digit: 1'b0, exp_digit: 1'b0, neg: 1'b0,
				mag: '0, mag_sat: 1'b0};
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction

		function void absorb_byte(octet_t c, bit last);
			bit first;
			bit after_mark;
			bit is_sign;
			bit fits;
			logic [dntr_pkg::INT_W+3:0] acc;
			dntr_pkg::tok_result_t r;
			first = scan.leading;
			after_mark = scan.just_marked;
			is_sign = (c == dntr_pkg::CHAR_PLUS) || (c == dntr_pkg::CHAR_MINUS);
			scan.leading = 1'b0;
			scan.just_marked = 1'b0;
			if (!scan.dead) begin
				if (c[7]) begin
					scan.dead = 1'b1;
				end else if (first && is_sign) begin
					scan.neg = (c == dntr_pkg::CHAR_MINUS);
				end else if (c >= dntr_pkg::CHAR_ZERO && c <= dntr_pkg::CHAR_NINE) begin
					if (scan.in_exp) begin
						scan.exp_digit = 1'b1;
					end else begin
						acc = {4'd0, scan.mag} * 10 + (c - dntr_pkg::CHAR_ZERO);
						scan.mant_digit = 1'b1;
						if (acc[dntr_pkg::INT_W+3:dntr_pkg::INT_W] != 0) begin
							scan.mag = '1;
							scan.mag_sat = 1'b1;
						end else begin
							scan.mag = acc[dntr_pkg::INT_W-1:0];
						end
					end
				end else if (c == dntr_pkg::CHAR_DOT && !scan.dot_seen && !scan.in_exp) begin
					scan.dot_seen = 1'b1;
				end else if ((c == dntr_pkg::CHAR_E_LO || c == dntr_pkg::CHAR_E_UP)
						&& !scan.in_exp) begin
					scan.in_exp = 1'b1;
					scan.just_marked = 1'b1;
				end else if (!(is_sign && scan.in_exp && !scan.exp_digit && after_mark)) begin
					scan.dead = 1'b1;
				end
			end
			if (!last)
				return;
			r = '0;
			r.number_class = dntr_pkg::CLASS_NONE;
			if (scan.dead || !scan.mant_digit || (scan.in_exp && !scan.exp_digit)) begin
				r.number_class = dntr_pkg::CLASS_NONE;
			end else if (scan.dot_seen || scan.in_exp) begin
				r.number_class = dntr_pkg::CLASS_REAL;
			end else begin
				if (scan.mag_sat)
					fits = 1'b0;
				else if (scan.neg)
					fits = scan.mag <= dntr_pkg::NEG_LIMIT;
				else
					fits = scan.mag <= dntr_pkg::POS_LIMIT;
				if (fits) begin
					r.number_class = dntr_pkg::CLASS_INT;
					r.int_value = scan.neg ? -scan.mag : scan.mag;
				end else begin
					r.number_class = dntr_pkg::CLASS_REAL;
					r.int_out_of_range = 1'b1;
				end
			end
			expected_results.push_back(r);
			clear_scan();
		endfunction

		function void match_result(logic [dntr_pkg::OUT_W-1:0] data,
				logic [dntr_pkg::USER_W-1:0] user);
			dntr_pkg::tok_result_t got;
			dntr_pkg::tok_result_t want;
			got.number_class = user[dntr_pkg::CLASS_W-1:0];
			got.int_out_of_range = user[dntr_pkg::CLASS_W];
			got.int_value = data;
			if (expected_results.size() == 0) begin
				$error("result word with nothing expected: %h %h", user, data);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (got.number_class !== want.number_class) begin
				$error("number_class expected %0d actual %0d", want.number_class,
					got.number_class);
				errors++;
			end
			if (got.int_value !== want.int_value) begin
				$error("int_value expected %0d actual %0d", $signed(want.int_value),
					$signed(got.int_value));
				errors++;
			end
			if (got.int_out_of_range !== want.int_out_of_range) begin
				$error("int_out_of_range expected %0d actual %0d", want.int_out_of_range,
					got.int_out_of_range);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic [dntr_pkg::BYTE_W-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tready = 1'b0;
	wire s_tready;
	wire m_tvalid;
	wire [dntr_pkg::OUT_W-1:0] m_tdata;
	wire [dntr_pkg::USER_W-1:0] m_tuser;

	literal_scoreboard board = new();
	bit send_quiet = 1'b0;
	bit recv_quiet = 1'b0;
	int unsigned sent_bytes = 0;

	string directed_tokens[$] = '{"0", "7", "2147483647", "-2147483648", "+2147483648",
		"-2147483649", "4294967296", "-0", "+", "-", "1.5", ".5", ".", "1.2.3", "6e7",
		"3E-2", "9e+1", "1e", "4e-", "1e5e2", "2e3.1", "5-3", "-+4", "1 2"};

	decimal_number_token_recognizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned draw_gap(inout bit quiet);
		if ($urandom_range(0, 31) == 0)
			quiet = !quiet;
		return quiet ? 0 : $urandom_range(0, 9);
	endfunction

	function automatic octet_q_t text_bytes(string s);
		octet_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	function automatic octet_t random_digit();
		return dntr_pkg::CHAR_ZERO + octet_t'($urandom_range(0, 9));
	endfunction

	function automatic octet_t stray_byte();
		case ($urandom_range(0, 6))
			0: return dntr_pkg::CHAR_DOT;
			1: return dntr_pkg::CHAR_E_LO;
			2: return dntr_pkg::CHAR_E_UP;
			3: return dntr_pkg::CHAR_PLUS;
			4: return dntr_pkg::CHAR_MINUS;
			5: return random_digit();
			default: return octet_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic octet_q_t random_token();
		octet_q_t q;
		int unsigned pick;
		int unsigned n;
		longint val;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			n = $urandom_range(1, 6);
			repeat (n) q.push_back(octet_t'($urandom_range(0, 255)));
			return q;
		end
		case ($urandom_range(0, 2))
			1: q.push_back(dntr_pkg::CHAR_PLUS);
			2: q.push_back(dntr_pkg::CHAR_MINUS);
			default: ;
		endcase
		if ($urandom_range(0, 7) == 0) begin
			if ($urandom_range(0, 2) == 0)
				val = longint'(64'd4294967291) + longint'($urandom_range(0, 8));
			else
				val = longint'(64'd2147483644) + longint'($urandom_range(0, 8));
			q = {q, text_bytes($sformatf("%0d", val))};
		end else begin
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 13) : $urandom_range(0, 5);
			repeat (n) q.push_back(random_digit());
		end
		if ($urandom_range(0, 3) == 0) begin
			q.push_back(dntr_pkg::CHAR_DOT);
			repeat ($urandom_range(0, 3)) q.push_back(random_digit());
		end
		if ($urandom_range(0, 3) == 0) begin
			q.push_back($urandom_range(0, 1) ? dntr_pkg::CHAR_E_LO : dntr_pkg::CHAR_E_UP);
			case ($urandom_range(0, 2))
				1: q.push_back(dntr_pkg::CHAR_PLUS);
				2: q.push_back(dntr_pkg::CHAR_MINUS);
				default: ;
			endcase
			repeat ($urandom_range(0, 3)) q.push_back(random_digit());
		end
		if (pick < 30) begin
			repeat ($urandom_range(1, 2)) begin
				if (q.size() > 1 && $urandom_range(0, 2) == 0)
					q.delete($urandom_range(0, q.size() - 1));
				else
					q.insert($urandom_range(0, q.size()), stray_byte());
			end
		end
		if (q.size() == 0)
			q.push_back(random_digit());
		return q;
	endfunction

	task automatic send_token(input octet_q_t bytes);
		int unsigned gap;
		bit last;
		for (int i = 0; i < bytes.size(); i++) begin
			last = (i == bytes.size() - 1);
			gap = draw_gap(send_quiet);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= bytes[i];
			s_tlast <= last;
			do @(posedge clk); while (!s_tready);
			board.absorb_byte(bytes[i], last);
			sent_bytes++;
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	initial begin
		octet_q_t q;
		bit paused;
		paused = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_tokens[i])
			send_token(text_bytes(directed_tokens[i]));
		q = '{8'h80};
		send_token(q);
		q = '{8'h31, 8'hff, 8'h32};
		send_token(q);
		q = '{8'h00};
		send_token(q);
		q = '{8'h35, 8'h00};
		send_token(q);
		drain_results();
		while (sent_bytes < 900) begin
			send_token(random_token());
			if (!paused && sent_bytes >= 450) begin
				paused = 1'b1;
				drain_results();
			end
		end
		drain_results();
		repeat (10) @(posedge clk);
		if (board.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int unsigned gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap(recv_quiet);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			board.match_result(m_tdata, m_tuser);
		end
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/dntr_pkg.sv
hw/rtl/dntr_step.sv
hw/rtl/decimal_number_token_recognizer.sv
hw/rtl/dntr_checker.sv
sim/testbench.sv
